// File: rtl/mme_pkg.sv
// Package: shared types and constants for the matrix multiply engine
`timescale 1ns / 1ps
package mme_pkg;
  localparam int MaxDim    = 16;
  localparam int IdxW      = $clog2(MaxDim);
  localparam int AddrW     = 2 * IdxW;
  localparam int Depth     = MaxDim * MaxDim;
  localparam int SizeW     = 5;
  localparam int ElemW     = 16;
  localparam int AccW      = 40;
  localparam int ProdW     = 2 * ElemW;

  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;
  localparam logic [1:0] OP_READ_C  = 2'd3;

  localparam logic [1:0] REG_A_ROWS    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_B_COLS    = 2'd2;

  // One classified command, passed from the front end to the back end
  typedef struct packed {
    logic [1:0]       op;
    logic             bad;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [ElemW-1:0] value;
  } cmd_t;

  // Clamp a size register to the store dimension
  function automatic logic [SizeW:0] eff_size(input logic [SizeW-1:0] r);
    logic [SizeW:0] m;
    m = (SizeW+1)'(MaxDim);
    return ({1'b0, r} > m) ? m : {1'b0, r};
  endfunction
endpackage

// File: rtl/mme_front.sv
// Front end: size registers, index check and a two-entry command queue
`timescale 1ns / 1ps
module mme_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mme_pkg::SizeW-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [mme_pkg::IdxW-1:0]   row,
  input  logic [mme_pkg::IdxW-1:0]   col,
  input  logic [mme_pkg::ElemW-1:0]  value,
  output logic                       q_valid,
  input  logic                       q_pop,
  output mme_pkg::cmd_t              q_cmd,
  output logic [mme_pkg::SizeW:0]    n_rows,
  output logic [mme_pkg::SizeW:0]    n_inner,
  output logic [mme_pkg::SizeW:0]    n_cols
);
  import mme_pkg::*;

  logic [SizeW-1:0] a_rows, inner_dim, b_cols;
  logic [SizeW:0]   lim_r, lim_c;
  cmd_t             fifo [2];
  logic             wptr, rptr;
  logic [1:0]       cnt;
  logic             push;
  cmd_t             cmd_in;

  assign n_rows  = eff_size(a_rows);
  assign n_inner = eff_size(inner_dim);
  assign n_cols  = eff_size(b_cols);

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= SizeW'(16);
      inner_dim <= SizeW'(16);
      b_cols    <= SizeW'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_ROWS:    a_rows    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_B_COLS:    b_cols    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify: bounds per op
  always_comb begin
    case (op)
      OP_WRITE_A: begin lim_r = n_rows;  lim_c = n_inner; end
      OP_WRITE_B: begin lim_r = n_inner; lim_c = n_cols;  end
      default:    begin lim_r = n_rows;  lim_c = n_cols;  end
    endcase
    cmd_in.op    = op;
    cmd_in.bad   = (op != OP_COMPUTE) &&
                   (({2'b0, row} >= lim_r) || ({2'b0, col} >= lim_c));
    cmd_in.row   = row;
    cmd_in.col   = col;
    cmd_in.value = value;
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = fifo[rptr];

  // Command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wptr] <= cmd_in;
  end
endmodule

// File: rtl/mme_back.sv
// Back end: element stores, shared multiply-accumulate and result register
`timescale 1ns / 1ps
module mme_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  mme_pkg::cmd_t              q_cmd,
  input  logic [mme_pkg::SizeW:0]    n_rows,
  input  logic [mme_pkg::SizeW:0]    n_inner,
  input  logic [mme_pkg::SizeW:0]    n_cols,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mme_pkg::AccW-1:0]   product,
  output logic                       status
);
  import mme_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_RUN, S_CMPI, S_CMPK, S_CMPW, S_RDWAIT, S_RDOUT
  } state_t;

  state_t state;

  logic [ElemW-1:0] a_mem [Depth];
  logic [ElemW-1:0] b_mem [Depth];
  logic [AccW-1:0]  c_mem [Depth];

  logic [AddrW:0]   clr_addr;
  logic [IdxW:0]    ci, cj, ck;
  logic [ElemW-1:0] a_rd, b_rd;
  logic [AccW-1:0]  c_rd;
  logic [ProdW-1:0] prod;
  logic [AccW-1:0]  acc;
  logic             mac_v, mac_v2, last1, last2;
  logic             a_we, b_we, c_we;
  logic [AddrW-1:0] a_wa, b_wa, c_wa, a_ra, b_ra, c_ra;
  logic [ElemW-1:0] ab_wd;
  logic [AccW-1:0]  c_wd;
  logic             take;

  // Out register is free when empty or being drained
  assign take  = !out_valid || !out_stall;
  // Compute and good reads leave the queue when their result is issued
  assign q_pop = (state == S_RDOUT) ||
                 ((state == S_RUN) && q_valid && take &&
                  !(q_cmd.op == OP_COMPUTE) && !(q_cmd.op == OP_READ_C && !q_cmd.bad));

  // Store port selection
  always_comb begin
    a_we  = 1'b0;
    b_we  = 1'b0;
    c_we  = 1'b0;
    a_wa  = {q_cmd.row, q_cmd.col};
    b_wa  = {q_cmd.row, q_cmd.col};
    ab_wd = q_cmd.value;
    c_wa  = {ci[IdxW-1:0], cj[IdxW-1:0]};
    // An empty inner dimension contributes nothing to the sum
    c_wd  = (n_inner == '0) ? acc : acc + AccW'($signed(prod));
    if (state == S_CLEAR) begin
      a_we = 1'b1; b_we = 1'b1; c_we = 1'b1;
      a_wa = clr_addr[AddrW-1:0];
      b_wa = clr_addr[AddrW-1:0];
      c_wa = clr_addr[AddrW-1:0];
      ab_wd = '0;
      c_wd  = '0;
    end else if (state == S_CMPI) begin
      c_we = 1'b1;
      c_wa = clr_addr[AddrW-1:0];
      c_wd = '0;
    end else if (q_pop && !q_cmd.bad) begin
      a_we = (q_cmd.op == OP_WRITE_A);
      b_we = (q_cmd.op == OP_WRITE_B);
    end else if (mac_v2 && last2) begin
      c_we = 1'b1;
    end
    a_ra = {ci[IdxW-1:0], ck[IdxW-1:0]};
    b_ra = {ck[IdxW-1:0], cj[IdxW-1:0]};
    c_ra = (state == S_RUN || state == S_RDWAIT) ? {q_cmd.row, q_cmd.col} : c_wa;
  end

  // Memories
  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_wa] <= ab_wd;
    a_rd <= a_mem[a_ra];
  end
  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_wa] <= ab_wd;
    b_rd <= b_mem[b_ra];
  end
  always_ff @(posedge clk) begin
    if (c_we) c_mem[c_wa] <= c_wd;
    c_rd <= c_mem[c_ra];
  end

  // Multiplier stage
  always_ff @(posedge clk) begin
    prod <= $signed(a_rd) * $signed(b_rd);
  end

  // Sequencer: clear pass, command issue, compute loop, read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      ci <= '0; cj <= '0; ck <= '0;
      mac_v <= 1'b0; mac_v2 <= 1'b0; last1 <= 1'b0; last2 <= 1'b0;
      acc       <= '0;
      out_valid <= 1'b0;
      product   <= '0;
      status    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      mac_v2 <= mac_v;
      last2  <= last1;
      mac_v  <= 1'b0;
      if (mac_v2) acc <= last2 ? '0 : c_wd;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (AddrW+1)'(Depth - 1)) state <= S_RUN;
        end
        S_RUN: begin
          if (q_valid && take) begin
            if (q_pop) begin
              out_valid <= 1'b1;
              product   <= '0;
              status    <= q_cmd.bad;
            end else if (q_cmd.op == OP_COMPUTE) begin
              clr_addr <= '0;
              state    <= S_CMPI;
            end else begin
              state <= S_RDWAIT;
            end
          end
        end
        S_CMPI: begin
          // Wipe C, one entry a cycle
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (AddrW+1)'(Depth - 1)) begin
            ci <= '0; cj <= '0; ck <= '0; acc <= '0;
            if (n_rows == '0 || n_cols == '0) state <= S_CMPW;
            else state <= S_CMPK;
          end
        end
        S_CMPK: begin
          // Issue one MAC per cycle; an empty inner dim issues a zero element
          mac_v <= 1'b1;
          last1 <= ({1'b0, ck} + 1'b1 >= n_inner);
          if ({1'b0, ck} + 1'b1 >= n_inner) begin
            ck    <= '0;
            state <= S_CMPW;
          end else begin
            ck <= ck + 1'b1;
          end
        end
        S_CMPW: begin
          // Wait for the pipeline to write the element, then advance
          if (!mac_v && !mac_v2 && !(n_rows == '0 || n_cols == '0) &&
              !({1'b0, ci} >= n_rows)) begin
            if ({1'b0, cj} + 1'b1 >= n_cols) begin
              cj <= '0;
              ci <= ci + 1'b1;
              state <= ({1'b0, ci} + 1'b1 >= n_rows) ? S_RDOUT : S_CMPK;
            end else begin
              cj <= cj + 1'b1;
              state <= S_CMPK;
            end
          end else if (!mac_v && !mac_v2) begin
            state <= S_RDOUT;
          end
        end
        S_RDWAIT: begin
          state <= S_RDOUT;
        end
        S_RDOUT: begin
          // Emit compute acknowledge or read data
          out_valid <= 1'b1;
          product   <= (q_cmd.op == OP_READ_C) ? c_rd : '0;
          status    <= 1'b0;
          state     <= S_RUN;
        end
        default: state <= S_RUN;
      endcase
    end
  end
endmodule

// File: rtl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine
`timescale 1ns / 1ps
// Computes C = A x B on signed Q4.12 elements with exact 40-bit accumulation.
// Ops: 0 writes A, 1 writes B, 2 computes C, 3 reads C; one result per item.
// After reset the stores are cleared in a pass during which queued items
// wait. All ops pass through a two-entry command queue; a read of C
// waits for the registered memory read. A compute first wipes C, then for
// each of the a_rows x b_cols elements issues max(inner_dim,1)
// multiply-accumulates on the single shared multiplier and waits for the
// pipeline to drain.
module matrix_multiply_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [mme_pkg::SizeW-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                op,
  input  logic [3:0]                row,
  input  logic [3:0]                col,
  input  logic signed [15:0]        value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [39:0]        product,
  output logic                      status
);
  import mme_pkg::*;

  logic          q_valid, q_pop;
  cmd_t          q_cmd;
  logic [SizeW:0] n_rows, n_inner, n_cols;
  logic [AccW-1:0] prod_u;

  mme_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .op, .row, .col, .value(value),
    .q_valid, .q_pop, .q_cmd, .n_rows, .n_inner, .n_cols
  );

  mme_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_cmd, .n_rows, .n_inner, .n_cols,
    .out_valid, .out_stall, .product(prod_u), .status
  );

  assign product = $signed(prod_u);
endmodule

// File: rtl/mme_checker.sv
// Port-level checker for the matrix multiply engine, bound to the top level
`timescale 1ns / 1ps
module mme_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [39:0] product,
  input logic        status
);

  // A held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(product) && $stable(status))
    else $error("stalled result changed");

  // An error result never carries data
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> product == '0)
    else $error("error result with nonzero product");

  // Nothing comes out during reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // A presented result is fully defined
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({product, status}))
    else $error("result carries unknown bits");
endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
  .clk, .rst, .out_valid, .out_stall,
  .product(product), .status
);
